FILE: hdl/pdwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdwd_pkg;

  localparam int unsigned MANT_W = 26;
  localparam int unsigned SH_W   = 5;
  localparam int unsigned DEN_W  = 35;  // normalized 5^k, leading one at bit 34
  localparam int unsigned REM_W  = 36;
  localparam int unsigned QUO_W  = 56;  // 53 bits + guard + round + one spare
  localparam int unsigned PROD_W = 61;
  localparam int unsigned NDIV   = QUO_W;

  localparam logic [3:0] EXP_MASK = 4'hf;

  // 5^k for k = 0..15, exact
  localparam logic [DEN_W-1:0] POW5 [16] = '{
    35'd1, 35'd5, 35'd25, 35'd125, 35'd625, 35'd3125, 35'd15625, 35'd78125,
    35'd390625, 35'd1953125, 35'd9765625, 35'd48828125, 35'd244140625,
    35'd1220703125, 35'd6103515625, 35'd30517578125
  };

  // floor(log2(5^k))
  localparam logic [5:0] POW5_LOG [16] = '{
    6'd0, 6'd2, 6'd4, 6'd6, 6'd9, 6'd11, 6'd13, 6'd16,
    6'd18, 6'd20, 6'd23, 6'd25, 6'd27, 6'd30, 6'd32, 6'd34
  };

  typedef struct packed {
    logic                    neg;
    logic                    zero;
    logic                    divf;
    logic signed [7:0]       ebase;
    logic [PROD_W-1:0]       prod;
  } side_t;

  function automatic logic [DEN_W-1:0] pow5_norm(input logic [3:0] k);
    logic [5:0] sh;
    sh = 6'd34 - POW5_LOG[k];
    return POW5[k] << sh;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/packed_decimal_word_to_double.sv
// Packed decimal word to binary64 converter.
// Input channel: packed_word_i with in_valid_i / in_stall_o. A transaction
// moves one 32-bit word: mantissa in bits 31..6, sign in bit 5, divide flag
// in bit 4, decimal exponent k in bits 3..0.
// Output channel: double_bits_o with out_valid_o / out_stall_i; one
// transaction per input word, in input order.
// Pipeline: decode/normalize, partial products, product sum, 56 quotient
// stages (one restoring bit each), then round and pack into the output
// register. One word is taken every cycle unless the output stall holds it.
// 10^k is split as 5^k * 2^k; both mantissa and 5^k are pre-normalized so
// the product or quotient needs at most a one-bit shift before rounding.
// Both paths run for every word; the divide flag picks the result at the end.
// Reset clears all valid bits; no payload is reset.
// When out_stall_i is high with a result waiting, the whole pipeline holds
// and in_stall_o rises; nothing is dropped or repeated. When the output
// register is empty the pipeline keeps moving regardless of out_stall_i.
`timescale 1ns / 1ps
`default_nettype none

module packed_decimal_word_to_double (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] packed_word_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic [63:0]      double_bits_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---- stage 1: decode, normalize mantissa, look up 5^k ----
  logic [pdwd_pkg::MANT_W-1:0] mant;
  logic [3:0]                  k;
  logic [pdwd_pkg::SH_W-1:0]   sh;
  logic [5:0]                  lg;
  logic                        divf;
  logic signed [7:0]           ebase;

  assign mant = packed_word_i[31:6];
  assign k    = packed_word_i[3:0] & pdwd_pkg::EXP_MASK;
  assign lg   = pdwd_pkg::POW5_LOG[k];
  assign divf = packed_word_i[4] && (k != 4'd0);

  // leading zero count of the mantissa
  always_comb begin
    sh = '0;
    for (int i = 0; i < pdwd_pkg::MANT_W; i++) begin
      if (mant[i]) sh = pdwd_pkg::SH_W'(pdwd_pkg::MANT_W - 1 - i);
    end
  end

  // exponent of the lower leading-bit position; +1 added later if higher
  always_comb begin
    if (divf) begin
      ebase = 8'sd24 - $signed({3'b000, sh}) - $signed({2'b00, lg})
              - $signed({4'b0000, k});
    end else begin
      ebase = 8'sd25 - $signed({3'b000, sh}) + $signed({2'b00, lg})
              + $signed({4'b0000, k});
    end
  end

  logic                        s1_vld_q;
  logic [pdwd_pkg::MANT_W-1:0] s1_mn_q;
  logic [pdwd_pkg::DEN_W-1:0]  s1_dn_q;
  logic                        s1_neg_q, s1_zero_q, s1_divf_q;
  logic signed [7:0]           s1_ebase_q;

  // ---- stage 2: partial products ----
  logic                        s2_vld_q;
  logic [43:0]                 s2_pplo_q;
  logic [42:0]                 s2_pphi_q;
  logic [pdwd_pkg::MANT_W-1:0] s2_mn_q;
  logic [pdwd_pkg::DEN_W-1:0]  s2_dn_q;
  logic                        s2_neg_q, s2_zero_q, s2_divf_q;
  logic signed [7:0]           s2_ebase_q;

  // ---- stage 3: product sum, divider operands ----
  logic                        s3_vld_q;
  logic [pdwd_pkg::REM_W-1:0]  s3_rem_q;
  logic [pdwd_pkg::DEN_W-1:0]  s3_dn_q;
  pdwd_pkg::side_t             s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mn_q    <= mant << sh;
      s1_dn_q    <= pdwd_pkg::pow5_norm(k);
      s1_neg_q   <= packed_word_i[5];
      s1_zero_q  <= (mant == '0);
      s1_divf_q  <= divf;
      s1_ebase_q <= ebase;

      s2_pplo_q  <= 44'(s1_mn_q) * 44'(s1_dn_q[17:0]);
      s2_pphi_q  <= 43'(s1_mn_q) * 43'(s1_dn_q[34:18]);
      s2_mn_q    <= s1_mn_q;
      s2_dn_q    <= s1_dn_q;
      s2_neg_q   <= s1_neg_q;
      s2_zero_q  <= s1_zero_q;
      s2_divf_q  <= s1_divf_q;
      s2_ebase_q <= s1_ebase_q;

      s3_rem_q        <= {1'b0, s2_mn_q, 9'b0};
      s3_dn_q         <= s2_dn_q;
      s3_side_q.neg   <= s2_neg_q;
      s3_side_q.zero  <= s2_zero_q;
      s3_side_q.divf  <= s2_divf_q;
      s3_side_q.ebase <= s2_ebase_q;
      s3_side_q.prod  <= pdwd_pkg::PROD_W'(s2_pplo_q)
                         + {s2_pphi_q[42:0], 18'b0};
    end
  end

  // ---- quotient stages ----
  logic                        dv_vld;
  logic [pdwd_pkg::QUO_W-1:0]  dv_quo;
  logic                        dv_rnz;
  pdwd_pkg::side_t             dv_side;

  pdwd_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s3_vld_q),
    .rem_i    (s3_rem_q),
    .den_i    (s3_dn_q),
    .side_i   (s3_side_q),
    .vld_o    (dv_vld),
    .quo_o    (dv_quo),
    .rem_nz_o (dv_rnz),
    .side_o   (dv_side)
  );

  // ---- round to nearest even and pack ----
  logic              lead, grd, stk, inc;
  logic [52:0]       sig;
  logic [53:0]       sum;
  logic signed [11:0] ex;
  logic [10:0]       bexp;
  logic [63:0]       bits_d;

  always_comb begin
    if (dv_side.divf) begin
      lead = dv_quo[55];
      sig  = lead ? dv_quo[55:3] : dv_quo[54:2];
      grd  = lead ? dv_quo[2] : dv_quo[1];
      stk  = lead ? (|dv_quo[1:0] | dv_rnz) : (dv_quo[0] | dv_rnz);
    end else begin
      lead = dv_side.prod[60];
      sig  = lead ? dv_side.prod[60:8] : dv_side.prod[59:7];
      grd  = lead ? dv_side.prod[7] : dv_side.prod[6];
      stk  = lead ? |dv_side.prod[6:0] : |dv_side.prod[5:0];
    end
    inc  = grd && (stk || sig[0]);
    sum  = {1'b0, sig} + {53'b0, inc};
    ex   = 12'(dv_side.ebase) + {11'b0, lead} + {11'b0, sum[53]} + 12'sd1023;
    bexp = ex[10:0];
    if (dv_side.zero) begin
      bits_d = {dv_side.neg, 63'b0};
    end else begin
      bits_d = {dv_side.neg, bexp, sum[53] ? 52'b0 : sum[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      double_bits_o <= bits_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pdwd_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring quotient bit per stage; sideband rides along.
module pdwd_div_pipe (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           vld_i,
  input  wire logic [pdwd_pkg::REM_W-1:0]     rem_i,
  input  wire logic [pdwd_pkg::DEN_W-1:0]     den_i,
  input  wire pdwd_pkg::side_t                side_i,
  output logic                                vld_o,
  output logic [pdwd_pkg::QUO_W-1:0]          quo_o,
  output logic                                rem_nz_o,
  output pdwd_pkg::side_t                     side_o
);

  localparam int unsigned N = pdwd_pkg::NDIV;

  logic                          vld_q [N];
  logic [pdwd_pkg::REM_W-1:0]    rem_q [N];
  logic [pdwd_pkg::REM_W-1:0]    rem_d [N];
  logic [pdwd_pkg::DEN_W-1:0]    den_q [N];
  logic [pdwd_pkg::QUO_W-1:0]    quo_q [N];
  logic [pdwd_pkg::QUO_W-1:0]    quo_d [N];
  pdwd_pkg::side_t               side_q [N];

  always_comb begin
    logic [pdwd_pkg::REM_W-1:0] r;
    logic [pdwd_pkg::DEN_W-1:0] d;
    logic [pdwd_pkg::QUO_W-1:0] q;
    logic [pdwd_pkg::REM_W:0]   t;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        r = rem_i;
        d = den_i;
        q = '0;
      end else begin
        r = rem_q[i-1];
        d = den_q[i-1];
        q = quo_q[i-1];
      end
      t = {1'b0, r} - {2'b00, d};
      if (!t[pdwd_pkg::REM_W]) begin
        rem_d[i] = {t[pdwd_pkg::REM_W-2:0], 1'b0};
        quo_d[i] = {q[pdwd_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_d[i] = {r[pdwd_pkg::REM_W-2:0], 1'b0};
        quo_d[i] = {q[pdwd_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < N; i++) vld_q[i] <= (i == 0) ? vld_i : vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i]  <= rem_d[i];
        quo_q[i]  <= quo_d[i];
        den_q[i]  <= (i == 0) ? den_i : den_q[i-1];
        side_q[i] <= (i == 0) ? side_i : side_q[i-1];
      end
    end
  end

  assign vld_o    = vld_q[N-1];
  assign quo_o    = quo_q[N-1];
  assign rem_nz_o = |rem_q[N-1];
  assign side_o   = side_q[N-1];

endmodule

`default_nettype wire

FILE: verif/packed_decimal_word_to_double_test.sv
`timescale 1ns / 1ps

module packed_decimal_word_to_double_test;

  // Word layout: mantissa 31..6, sign 5, divide flag 4, exponent 3..0
  localparam logic [31:0] SIGN_FLAG = 32'h0000_0020;
  localparam logic [31:0] DIV_FLAG  = 32'h0000_0010;
  localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam int unsigned PIPE_LAT  = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  typedef enum int {
    PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
  } idle_phase_e;

  typedef struct {
    logic [31:0] word;
    logic [63:0] bits;
    bit          typed;  // expected value given in the row
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic [31:0] packed_word_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] double_bits_o;
  logic        out_valid_o;
  logic        out_stall_i;

  logic [63:0] pending_doubles[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  packed_decimal_word_to_double u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .packed_word_i (packed_word_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .double_bits_o (double_bits_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  // Simulator reals are binary64: exact 10^k (k <= 15) and one rounding,
  // nearest-even, match the block's arithmetic.
  function automatic logic [63:0] decimal_to_double(input logic [31:0] word);
    real         mag;
    real         scale;
    logic [63:0] bits;
    mag   = real'(word[31:6]);
    scale = 1.0;
    for (int i = 0; i < int'(word[3:0]); i++) begin
      scale = scale * 10.0;
    end
    if (word[3:0] != 4'd0) begin
      if ((word & DIV_FLAG) != 0) begin
        mag = mag / scale;
      end else begin
        mag = mag * scale;
      end
    end
    bits = $realtobits(mag);
    if ((word & SIGN_FLAG) != 0) begin
      bits[63] = ~bits[63];
    end
    return bits;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure, random per the current phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output checker: one transaction per accepted word, in order
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_doubles.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) begin
          $display("unexpected result %h", double_bits_o);
        end
      end else begin
        if (double_bits_o !== pending_doubles[0]) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) begin
            $display("double_bits mismatch: expected %h actual %h",
                     pending_doubles[0], double_bits_o);
          end
        end
        void'(pending_doubles.pop_front());
      end
    end
  end

  // Present one word; hold it until taken, then maybe go idle a while.
  task automatic send_word(input logic [31:0] word, input logic [63:0] bits);
    packed_word_i <= word;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_doubles.insert(pending_doubles.size(), bits);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_doubles.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_word;
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(7))
      0: word[31:6] = '1;              // largest mantissa
      1: word[31:6] = '0;              // zero, signed zero
      2: word[31:6] = 26'($urandom_range(1, 99));
      3: word[3:0]  = 4'd0;            // divide flag ignored
      default: ;
    endcase
    return word;
  endfunction

  vec_t directed[] = '{
    '{32'h0000_0000, 64'h0, 1'b1},
    '{32'h0000_0020, NEG_ZERO, 1'b1},
    '{32'h0000_003F, NEG_ZERO, 1'b1},       // zero, all flags, k = 15
    '{32'h0000_001F, 64'h0, 1'b1},
    '{32'h0000_0040, ONE_BITS, 1'b1},
    '{32'h0000_0050, ONE_BITS, 1'b1},       // divide flag, k = 0
    '{32'h0000_0060, 64'hBFF0_0000_0000_0000, 1'b1},
    '{32'h0000_0041, 64'h4024_0000_0000_0000, 1'b1},   // 10.0
    '{32'h0000_0051, 64'h0, 1'b0},          // 0.1
    '{32'h0000_004F, 64'h0, 1'b0},
    '{32'h0000_005F, 64'h0, 1'b0},
    '{32'hFFFF_FFC0, 64'h0, 1'b0},
    '{32'hFFFF_FFD0, 64'h0, 1'b0},
    '{32'hFFFF_FFCF, 64'h0, 1'b0},
    '{32'hFFFF_FFDF, 64'h0, 1'b0},
    '{32'hFFFF_FFEF, 64'h0, 1'b0},
    '{32'hFFFF_FFFF, 64'h0, 1'b0},
    '{32'h0000_00D3, 64'h0, 1'b0},          // 3 / 1000
    '{32'h0000_0097, 64'h0, 1'b0},
    '{32'h5555_5555, 64'h0, 1'b0},
    '{32'hAAAA_AAAA, 64'h0, 1'b0},
    '{32'h0000_0F9A, 64'h0, 1'b0}
  };

  initial begin
    idle_phase_e phase;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    packed_word_i  = '0;
    out_stall_i    = 1'b0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed rows give their own expected value, the rest use the predictor
    foreach (directed[i]) begin
      if (directed[i].typed) begin
        send_word(directed[i].word, directed[i].bits);
      end else begin
        send_word(directed[i].word, decimal_to_double(directed[i].word));
      end
    end
    drain();

    // Random words through each idling phase; full drain between phases
    phase = PH_NONE;
    repeat (4) begin
      case (phase)
        PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PH_SEND_IDLE:  begin send_idle_pct = 80; recv_stall_pct = 0;  end
        PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default:       begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        logic [31:0] word;
        word = random_word();
        send_word(word, decimal_to_double(word));
      end
      drain();
      phase = idle_phase_e'(int'(phase) + 1);
    end

    recv_stall_pct = 0;
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_doubles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
